### sv/amgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amgt_pkg
// Shared constants of the adjacency matrix graph table.
// ----------------------------------------------------------------------------
package amgt_pkg;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned OpW     = 3;
  localparam int unsigned VidW    = 32;
  localparam int unsigned WeightW = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SumW    = 38;
  localparam int unsigned DegW    = 6;
  localparam int unsigned CntW    = 7;

  localparam logic [OpW-1:0] OpInsVertex = 3'd0;
  localparam logic [OpW-1:0] OpInsEdge   = 3'd1;
  localparam logic [OpW-1:0] OpEraVertex = 3'd2;
  localparam logic [OpW-1:0] OpUpdEdge   = 3'd3;
  localparam logic [OpW-1:0] OpWeightSum = 3'd4;
  localparam logic [OpW-1:0] OpMinDegree = 3'd5;

  localparam logic [StatusW-1:0] StOk          = 3'd0;
  localparam logic [StatusW-1:0] StExists      = 3'd1;
  localparam logic [StatusW-1:0] StBothMissing = 3'd2;
  localparam logic [StatusW-1:0] StOneMissing  = 3'd3;
  localparam logic [StatusW-1:0] StEdgeExists  = 3'd4;
  localparam logic [StatusW-1:0] StNoEdge      = 3'd5;
  localparam logic [StatusW-1:0] StEmpty       = 3'd6;
  localparam logic [StatusW-1:0] StFull        = 3'd7;

  // input tdata: op[2:0], vid_a[34:3], vid_b[66:35], weight[98:67], pad to 104
  localparam int unsigned InDataW  = 104;
  // output tdata: status, result_vid, result_sum, result_degree, result_count; 86 -> 88
  localparam int unsigned OutDataW = 88;

endpackage

### sv/amgt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amgt_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module amgt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

### sv/adjacency_matrix_graph_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_table
// Undirected weighted graph: vertex slot table plus adjacency matrix in RAM.
// ----------------------------------------------------------------------------
// s_axis takes one operation per transfer (op, vid_a, vid_b, weight);
// m_axis returns exactly one result per operation. One op is in work at a time.
// Steps from accept to result valid (N = MAX_VERTICES):
//   every op scans the slot table first, then decides.
//   insert vertex, min degree, unknown op, failed lookups: result after the decision
//   insert/update edge: edge read, mirrored writes, degree bumps
//   weight sum: one matrix row walked
//   erase vertex: S_ERA0 and S_ERA1 for each slot, plus S_ERA2 where an edge is cleared
// The next op can be taken in the cycle after the result transfer.
// Reset: slot valid bits clear at once; the matrix present bits are cleared
//   by a pass over all 2^(2*clog2(N)) entries (4096 for N = 64), with
//   s_axis_tready low during it.
// Stall: the result waits in output registers while m_axis_tready is low;
//   no new op is taken until it is transferred.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_table
  import amgt_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // op[2:0] vid_a[34:3] vid_b[66:35] weight[98:67], zero pad
  input  logic [amgt_pkg::InDataW-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // status[2:0] result_vid[34:3] result_sum[72:35] result_degree[78:73]
  // result_count[85:79], zero pad
  output logic [amgt_pkg::OutDataW-1:0] m_axis_tdata
);
  localparam int unsigned N  = MAX_VERTICES;
  localparam int unsigned SW = $clog2(N);
  localparam int unsigned MW = 2 * SW;
  localparam int unsigned MD = 1 << MW;
  localparam int unsigned NW = $clog2(N + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_EDGE_CHK, S_EDGE_WR, S_DEG_B,
    S_ROW, S_ERA0, S_ERA1, S_ERA2, S_OUT
  } state_e;

  state_e state_q;
  logic [MW-1:0] clr_q;
  logic [OpW-1:0] op_q;
  logic [VidW-1:0] a_q, b_q;
  logic [WeightW-1:0] w_q;
  logic [SW:0] idx_q;          // walk index, one wider to hold N
  logic        rv_q;           // read issued last cycle
  logic [SW-1:0] ridx_q;       // slot of the read in flight
  logic        fa_q, fb_q, ff_q;
  logic [SW-1:0] sa_q, sb_q, free_q;
  logic [SW-1:0] dega_q, degb_q;
  logic        best_v_q;
  logic [VidW-1:0] best_id_q;
  logic [SW-1:0] best_deg_q;
  logic [NW-1:0] cnt_q;
  logic [SumW-1:0] sum_q;
  logic [N-1:0] valid_q;
  logic [StatusW-1:0] st_q;
  logic [VidW-1:0] rvid_q;
  logic [DegW-1:0] rdeg_q;
  logic [CntW-1:0] rcnt_q;

  // slot RAM: {id, degree}
  logic slot_we;
  logic [SW-1:0] slot_addr;
  logic [VidW+SW-1:0] slot_wd, slot_rd;
  // matrix RAM: {present, weight}, address {row, col}
  logic mat_we;
  logic [MW-1:0] mat_addr;
  logic [WeightW:0] mat_wd, mat_rd;

  amgt_ram #(.Width(VidW + SW), .Depth(N)) u_slot (
    .clk_i, .we_i(slot_we), .addr_i(slot_addr), .wdata_i(slot_wd), .rdata_o(slot_rd)
  );
  amgt_ram #(.Width(WeightW + 1), .Depth(MD)) u_mat (
    .clk_i, .we_i(mat_we), .addr_i(mat_addr), .wdata_i(mat_wd), .rdata_o(mat_rd)
  );

  logic [VidW-1:0] rd_id;
  logic [SW-1:0]   rd_deg;
  logic            rd_present;
  assign rd_id      = slot_rd[VidW+SW-1:SW];
  assign rd_deg     = slot_rd[SW-1:0];
  assign rd_present = mat_rd[WeightW];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {2'b00, rcnt_q, rdeg_q, sum_q, rvid_q, st_q};

  logic bump;  // edge insert between two distinct slots
  assign bump = (op_q == OpInsEdge) && (sa_q != sb_q);

  // RAM port control
  always_comb begin
    slot_we   = 1'b0;
    slot_addr = idx_q[SW-1:0];
    slot_wd   = '0;
    mat_we    = 1'b0;
    mat_addr  = {sa_q, idx_q[SW-1:0]};
    mat_wd    = '0;
    case (state_q)
      S_CLEAR: begin
        mat_we   = 1'b1;
        mat_addr = clr_q;
      end
      S_DECIDE: begin
        mat_addr = {sa_q, sb_q};  // edge lookup for edge ops
        if (op_q == OpInsVertex && !fa_q && ff_q) begin
          slot_we   = 1'b1;
          slot_addr = free_q;
          slot_wd   = {a_q, {SW{1'b0}}};
        end
      end
      S_EDGE_CHK: begin
        mat_addr = {sa_q, sb_q};
        mat_we   = (op_q == OpInsEdge) ? !rd_present : rd_present;
        mat_wd   = {1'b1, w_q};
      end
      S_EDGE_WR: begin
        mat_addr = {sb_q, sa_q};
        mat_we   = 1'b1;
        mat_wd   = {1'b1, w_q};
        if (bump) begin
          slot_we   = 1'b1;
          slot_addr = sa_q;
          slot_wd   = {a_q, dega_q + 1'b1};
        end
      end
      S_DEG_B: begin
        slot_we   = 1'b1;
        slot_addr = sb_q;
        slot_wd   = {b_q, degb_q + 1'b1};
      end
      S_ERA1: begin
        // clear row entry; neighbor loses one degree
        mat_we  = rd_present;
        slot_we = rd_present && (idx_q[SW-1:0] != sa_q);
        slot_wd = {rd_id, rd_deg - 1'b1};
      end
      S_ERA2: begin
        mat_addr = {idx_q[SW-1:0], sa_q};
        mat_we   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      op_q       <= '0;
      a_q        <= '0;
      b_q        <= '0;
      w_q        <= '0;
      idx_q      <= '0;
      rv_q       <= 1'b0;
      ridx_q     <= '0;
      fa_q       <= 1'b0;
      fb_q       <= 1'b0;
      ff_q       <= 1'b0;
      sa_q       <= '0;
      sb_q       <= '0;
      free_q     <= '0;
      dega_q     <= '0;
      degb_q     <= '0;
      best_v_q   <= 1'b0;
      best_id_q  <= '0;
      best_deg_q <= '0;
      cnt_q      <= '0;
      sum_q      <= '0;
      valid_q    <= '0;
      st_q       <= StOk;
      rvid_q     <= '0;
      rdeg_q     <= '0;
      rcnt_q     <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) state_q <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid) begin
          op_q <= s_axis_tdata[2:0];
          a_q  <= s_axis_tdata[34:3];
          b_q  <= s_axis_tdata[66:35];
          w_q  <= s_axis_tdata[98:67];
          idx_q <= '0; rv_q <= 1'b0;
          fa_q <= 1'b0; fb_q <= 1'b0; ff_q <= 1'b0; best_v_q <= 1'b0; cnt_q <= '0;
          sum_q <= '0; rvid_q <= '0; rdeg_q <= '0; rcnt_q <= '0; st_q <= StOk;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          // one slot read a cycle; data of the previous read is judged here
          if (rv_q) begin
            if (valid_q[ridx_q]) begin
              if (rd_id == a_q) begin fa_q <= 1'b1; sa_q <= ridx_q; dega_q <= rd_deg; end
              if (rd_id == b_q) begin fb_q <= 1'b1; sb_q <= ridx_q; degb_q <= rd_deg; end
              if (!best_v_q || rd_deg < best_deg_q) begin
                best_v_q <= 1'b1; best_id_q <= rd_id;
                best_deg_q <= rd_deg; cnt_q <= NW'(1);
              end else if (rd_deg == best_deg_q) begin
                cnt_q <= cnt_q + 1'b1;
                if ($signed(rd_id) < $signed(best_id_q)) best_id_q <= rd_id;
              end
            end else if (!ff_q) begin
              ff_q <= 1'b1; free_q <= ridx_q;  // lowest free slot
            end
          end
          rv_q   <= (idx_q < (SW + 1)'(N));
          ridx_q <= idx_q[SW-1:0];
          if (idx_q == (SW + 1)'(N)) state_q <= S_DECIDE;
          else idx_q <= idx_q + 1'b1;
        end
        S_DECIDE: begin
          state_q <= S_OUT;
          case (op_q)
            OpInsVertex: begin
              if (fa_q) st_q <= StExists;
              else if (!ff_q) st_q <= StFull;
              else valid_q[free_q] <= 1'b1;
            end
            OpInsEdge, OpUpdEdge: begin
              if (!fa_q && !fb_q) st_q <= StBothMissing;
              else if (!fa_q || !fb_q) begin
                st_q <= StOneMissing; rvid_q <= fa_q ? b_q : a_q;
              end else state_q <= S_EDGE_CHK;
            end
            OpEraVertex: begin
              if (!fa_q) begin st_q <= StOneMissing; rvid_q <= a_q; end
              else begin
                idx_q <= '0;
                state_q <= S_ERA0;
              end
            end
            OpWeightSum: begin
              if (!fa_q) begin st_q <= StOneMissing; rvid_q <= a_q; end
              else begin
                idx_q <= '0; rv_q <= 1'b0;
                state_q <= S_ROW;
              end
            end
            OpMinDegree: begin
              if (!best_v_q) st_q <= StEmpty;
              else begin
                rvid_q <= best_id_q; rdeg_q <= DegW'(best_deg_q);
                rcnt_q <= CntW'(cnt_q);
              end
            end
            default: ;  // unknown op: no change, all-zero result
          endcase
        end
        S_EDGE_CHK: begin
          if (op_q == OpInsEdge && rd_present) begin
            st_q <= StEdgeExists; state_q <= S_OUT;
          end else if (op_q == OpUpdEdge && !rd_present) begin
            st_q <= StNoEdge; state_q <= S_OUT;
          end else state_q <= S_EDGE_WR;
        end
        S_EDGE_WR: state_q <= bump ? S_DEG_B : S_OUT;
        S_DEG_B: state_q <= S_OUT;
        S_ROW: begin
          if (rv_q && rd_present && ridx_q != sa_q) begin
            sum_q <= sum_q + {{(SumW - WeightW){mat_rd[WeightW-1]}}, mat_rd[WeightW-1:0]};
          end
          rv_q   <= (idx_q < (SW + 1)'(N));
          ridx_q <= idx_q[SW-1:0];
          if (idx_q == (SW + 1)'(N)) state_q <= S_OUT;
          else idx_q <= idx_q + 1'b1;
        end
        S_ERA0: state_q <= S_ERA1;
        S_ERA1: begin
          if (rd_present) state_q <= S_ERA2;
          else if (idx_q == (SW + 1)'(N - 1)) begin
            valid_q[sa_q] <= 1'b0; state_q <= S_OUT;
          end else begin
            idx_q <= idx_q + 1'b1; state_q <= S_ERA0;
          end
        end
        S_ERA2: begin
          if (idx_q == (SW + 1)'(N - 1)) begin
            valid_q[sa_q] <= 1'b0; state_q <= S_OUT;
          end else begin
            idx_q <= idx_q + 1'b1; state_q <= S_ERA0;
          end
        end
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### sv/amgt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amgt_checker
// Port-level checks of the graph table, bound to the top level.
// ----------------------------------------------------------------------------
module amgt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second op taken while busy");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready while result pending");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[87:86] == 2'b00)
    else $error("pad bits set");
endmodule

bind adjacency_matrix_graph_table amgt_checker u_amgt_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata
);
